@@ rtl/ssms_pkg.sv @@
// shared constants and types for the stock span unit
package ssms_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int PRICE_BITS = 32;

  // fixed port widths
  localparam int PRICE_IN_W = 32;
  localparam int SPAN_W     = 11;

  // derived widths
  localparam int POS_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [PRICE_BITS-1:0] price_t;

  typedef struct packed {
    pos_t   pos;
    price_t value;
  } entry_t;

  // access request from the sequencer to the stack memory
  typedef struct packed {
    logic   rd_en;
    pos_t   rd_addr;
    logic   wr_en;
    pos_t   wr_addr;
    entry_t wr_data;
  } stack_req_t;

endpackage

@@ rtl/stock_span_monotonic_stack_unit.sv @@
// stock span unit: sequencer over a monotonic stack with one shared compare/subtract unit
// steps: CHECK, a CMP per stack entry compared, PUSH, OUT; on overflow CHECK goes to OUT
// one request at a time: item_stall stays high from acceptance until the result
//   is loaded into the output register; each stack entry is popped at most once
// reset: synchronous, clears sequencer, stack fill and item count; the stack
//   memory itself is not cleared since only entries below the fill are read
module stock_span_monotonic_stack_unit import ssms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [PRICE_IN_W-1:0] price,
  input  logic                  first,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [SPAN_W-1:0]     span,
  output logic                  overflow
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  cnt_t              fill;
  cnt_t              fill_next;
  cnt_t              count;
  cnt_t              count_next;
  price_t            cur_price;
  logic [SPAN_W-1:0] span_r;
  logic [SPAN_W-1:0] span_r_next;
  logic              ovf_r;
  logic              ovf_r_next;

  stack_req_t req;
  entry_t     rd_data;
  cnt_t       rd_index;
  logic       pop;
  logic       out_load;

  ssms_stack u_stack (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign item_stall = (state != S_IDLE);
  assign out_load   = (state == S_OUT) && (!result_valid || !result_stall);

  // shared compare: top entry is popped when its price is not above the new one
  assign pop = (rd_data.value <= cur_price);

  // read the top in CHECK, the entry below the popped top in CMP
  assign rd_index = (state == S_CMP) ? fill - cnt_t'(2) : fill - cnt_t'(1);

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    count_next  = count;
    span_r_next = span_r;
    ovf_r_next  = ovf_r;
    req         = '0;
    req.rd_addr = rd_index[POS_W-1:0];
    req.wr_addr = fill[POS_W-1:0];
    req.wr_data = '{pos: count[POS_W-1:0], value: cur_price};
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (first) begin
            fill_next  = '0;
            count_next = '0;
          end
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (count >= cnt_t'(MAX_ITEMS)) begin
          span_r_next = '0;
          ovf_r_next  = 1'b1;
          state_next  = S_OUT;
        end else if (fill == '0) begin
          span_r_next = SPAN_W'(count + cnt_t'(1));
          ovf_r_next  = 1'b0;
          state_next  = S_PUSH;
        end else begin
          req.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ovf_r_next = 1'b0;
        if (pop) begin
          fill_next = fill - cnt_t'(1);
          if (fill == cnt_t'(1)) begin
            span_r_next = SPAN_W'(count + cnt_t'(1));
            state_next  = S_PUSH;
          end else begin
            req.rd_en = 1'b1;
          end
        end else begin
          span_r_next = SPAN_W'(count - cnt_t'(rd_data.pos));
          state_next  = S_PUSH;
        end
      end
      S_PUSH: begin
        req.wr_en  = 1'b1;
        fill_next  = fill + cnt_t'(1);
        count_next = count + cnt_t'(1);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      count <= count_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cur_price <= PRICE_BITS'(price);
    end
    span_r <= span_r_next;
    ovf_r  <= ovf_r_next;
    if (out_load) begin
      span     <= span_r;
      overflow <= ovf_r;
    end
  end

  // every stack entry belongs to an item of the current series
  a_fill_le_count: assert property (@(posedge clk) disable iff (rst) fill <= count)
    else $error("stack fill exceeds item count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_ITEMS))
    else $error("item count beyond series limit");

  a_ovf_span: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflow) |-> (span == '0))
    else $error("overflow result with nonzero span");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second request taken while busy");

  a_push_in_series: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (count < cnt_t'(MAX_ITEMS)))
    else $error("push beyond series limit");

endmodule

@@ rtl/ssms_stack.sv @@
// stack memory holding (position, price) entries, with a registered read port and a write port
module ssms_stack import ssms_pkg::*; (
  input  logic       clk,
  input  stack_req_t req,
  output entry_t     rd_data
);

  entry_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
